FILE: rtl/core/des_ks_pkg.sv
// Package for the DES key schedule: widths, PC-1/PC-2 tables, shift schedule,
// and the bit-selection and rotate functions. No dependencies.

package des_ks_pkg;

  localparam int KEY_W    = 64;
  localparam int HALF_W   = 28;
  localparam int CD_W     = 2 * HALF_W;
  localparam int SUBKEY_W = 48;
  localparam int ROUNDS   = 16;
  localparam int RND_W    = 4;

  localparam logic [RND_W-1:0] RND_FIRST = RND_W'(0);
  localparam logic [RND_W-1:0] RND_LAST  = RND_W'(ROUNDS - 1);

  // Bit r set: round r rotates both halves by two places, else by one.
  localparam logic [15:0] SHIFT2_MASK = 16'h7EFC;

  typedef struct packed {
    logic [HALF_W-1:0] c;
    logic [HALF_W-1:0] d;
  } ks_cd_t;

  // Table entries count from 1 at the most significant bit.
  localparam logic [6:0] PC1_TAB [0:55] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
    7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
    7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [0:47] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // PC-1: drop the parity bits, split into C and D.
  function automatic ks_cd_t pc1(input logic [KEY_W-1:0] key);
    logic [CD_W-1:0] res;
    logic [5:0]      idx;
    res = '0;
    for (int i = 0; i < CD_W; i++) begin
      idx = 6'(7'd64 - PC1_TAB[i]);
      res[CD_W-1-i] = key[idx];
    end
    return ks_cd_t'(res);
  endfunction

  // PC-2: select 48 of the 56 joined C:D bits.
  function automatic logic [SUBKEY_W-1:0] pc2(input ks_cd_t cd);
    logic [SUBKEY_W-1:0] res;
    logic [CD_W-1:0]     w;
    logic [5:0]          idx;
    res = '0;
    w   = cd;
    for (int i = 0; i < SUBKEY_W; i++) begin
      idx = 6'(7'd56 - {1'b0, PC2_TAB[i]});
      res[SUBKEY_W-1-i] = w[idx];
    end
    return res;
  endfunction

  function automatic logic [HALF_W-1:0] rot28(input logic [HALF_W-1:0] v,
                                              input logic two);
    logic [HALF_W-1:0] res;
    if (two) begin
      res = {v[HALF_W-3:0], v[HALF_W-1:HALF_W-2]};
    end else begin
      res = {v[HALF_W-2:0], v[HALF_W-1]};
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/des_key_schedule.sv
// DES key schedule top level: key intake, round state and output register.
// Depends on des_ks_pkg and des_ks_round.

// Each key transaction on the input yields sixteen 48-bit round subkeys on the
// output, in round order, one per cycle, with tuser carrying the round number
// and tlast marking the sixteenth. Subkeys come from the single round unit,
// which the C/D register feeds once per cycle while not stalled. The next key
// is accepted in the cycle its predecessor's last round is computed, so keys
// stream back to back at one subkey per cycle; out_tready low stalls the round
// unit and holds the current subkey. Parity bits of the key are ignored.
// Reset clears the control state only; no clearing pass is needed.

module des_key_schedule
  import des_ks_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [KEY_W-1:0]    in_tdata,   // [63:0] key
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [SUBKEY_W-1:0] out_tdata,  // [47:0] subkey
  output logic [RND_W-1:0]    out_tuser,  // [3:0] round_index
  output logic                out_tlast   // last subkey of the key
);

  logic                busy_r, busy_nxt;
  ks_cd_t              cd_r, cd_nxt;
  logic [RND_W-1:0]    rnd_r, rnd_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SUBKEY_W-1:0] subkey_r, subkey_nxt;
  logic [RND_W-1:0]    out_rnd_r, out_rnd_nxt;
  logic                out_last_r, out_last_nxt;

  ks_cd_t              cd_rot;
  logic [SUBKEY_W-1:0] subkey;
  logic                advance;
  logic                last_rnd;
  logic                load;

  des_ks_round u_round (
    .cd     (cd_r),
    .rnd    (rnd_r),
    .cd_rot (cd_rot),
    .subkey (subkey)
  );

  // Compute a round whenever the output register is free or being drained.
  assign advance   = busy_r && (!out_valid_r || out_tready);
  assign last_rnd  = (rnd_r == RND_LAST);
  // Take a new key when idle, or as the current key finishes its last round.
  assign in_tready = !busy_r || (advance && last_rnd);
  assign load      = in_tvalid && in_tready;

  always_comb begin
    busy_nxt = busy_r;
    cd_nxt   = cd_r;
    rnd_nxt  = rnd_r;
    if (load) begin
      busy_nxt = 1'b1;
      cd_nxt   = pc1(in_tdata);
      rnd_nxt  = RND_FIRST;
    end else if (advance) begin
      busy_nxt = !last_rnd;
      cd_nxt   = cd_rot;
      rnd_nxt  = rnd_r + RND_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    subkey_nxt    = subkey_r;
    out_rnd_nxt   = out_rnd_r;
    out_last_nxt  = out_last_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      subkey_nxt    = subkey;
      out_rnd_nxt   = rnd_r;
      out_last_nxt  = last_rnd;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      rnd_r       <= RND_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    cd_r       <= cd_nxt;
    subkey_r   <= subkey_nxt;
    out_rnd_r  <= out_rnd_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = subkey_r;
  assign out_tuser  = out_rnd_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/core/des_ks_round.sv
// One DES key-schedule round: rotate C and D by the schedule, apply PC-2.
// Depends on des_ks_pkg.

module des_ks_round
  import des_ks_pkg::*;
(
  input  ks_cd_t              cd,
  input  logic [RND_W-1:0]    rnd,
  output ks_cd_t              cd_rot,
  output logic [SUBKEY_W-1:0] subkey
);

  logic two;

  assign two      = SHIFT2_MASK[rnd];
  assign cd_rot.c = rot28(cd.c, two);
  assign cd_rot.d = rot28(cd.d, two);
  assign subkey   = pc2(cd_rot);

endmodule
